[hw/rtl/position_history_rewind_macros.svh]
// Assertion macros shared by the checker of the position history rewind block.
`ifndef POSITION_HISTORY_REWIND_MACROS_SVH
`define POSITION_HISTORY_REWIND_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PRH_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PRH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/prh_pkg.sv]
// Types and constants shared by the position history rewind block.
package prh_pkg;

  localparam int unsigned TIME_W = 31;
  localparam int unsigned POS_W  = 32;
  localparam int unsigned FT_W   = 10;
  localparam int unsigned MR_W   = 12;

  localparam logic [FT_W-1:0] DEFAULT_FRAME_MS = 10'd25;
  localparam logic [MR_W-1:0] RESET_MAX_REWIND = 12'd1000;

  localparam logic [1:0] ST_POSITION = 2'd0;
  localparam logic [1:0] ST_RECENT   = 2'd1;
  localparam logic [1:0] ST_NO_HIST  = 2'd2;

  localparam logic REG_FRAME_TIME = 1'b0;
  localparam logic REG_MAX_REWIND = 1'b1;

  typedef struct packed {
    logic                    vld;
    logic [TIME_W-1:0]       t;
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
  } prh_word_t;

  typedef struct packed {
    logic clr;
    logic cap;
    logic load_q;
    logic rd;
    logic chk;
    logic mul;
    logic div_fin;
    logic out_load;
  } prh_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic walk_go;
    logic walk_stop;
    logic interp;
    logic div_done;
    logic last_axis;
    logic out_free;
  } prh_sts_t;

endpackage

[hw/rtl/prh_req_if.sv]
// Input item channel carrying capture and query transactions.
interface prh_req_if;
  logic                    valid;
  logic                    ready;
  logic                    cmd;
  logic [5:0]              client;
  logic [30:0]             time_ms;
  logic [30:0]             command_time_ms;
  logic                    alive;
  logic signed [31:0]      pos_x;
  logic signed [31:0]      pos_y;
  logic signed [31:0]      pos_z;
  logic                    frame_end;
  modport source (output valid, cmd, client, time_ms, command_time_ms, alive,
                  pos_x, pos_y, pos_z, frame_end, input ready);
  modport sink (input valid, cmd, client, time_ms, command_time_ms, alive,
                pos_x, pos_y, pos_z, frame_end, output ready);
endinterface

[hw/rtl/prh_rsp_if.sv]
// Result channel carrying one transaction per query.
interface prh_rsp_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic [30:0]        used_time_ms;
  modport source (output valid, status, out_x, out_y, out_z, used_time_ms, input ready);
  modport sink (input valid, status, out_x, out_y, out_z, used_time_ms, output ready);
endinterface

[hw/rtl/prh_cfg_if.sv]
// Configuration write channel.
interface prh_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [11:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[hw/rtl/prh_div.sv]
// Restoring divider that produces one quotient bit per cycle.
module prh_div import prh_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [63:0]       dividend,
  input  logic [TIME_W-1:0] divisor,
  output logic              done,
  output logic [32:0]       quotient
);
  logic              busy;
  logic [5:0]        cnt;
  logic [31:0]       rem;
  logic [63:0]       dvd;
  logic [TIME_W-1:0] den;
  logic [31:0]       r2;
  logic              qbit;

  assign r2       = {rem[30:0], dvd[63]};
  assign qbit     = (r2 >= {1'b0, den});
  assign quotient = dvd[32:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (&cnt) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      den <= divisor;
      rem <= '0;
    end else if (busy) begin
      rem <= qbit ? (r2 - {1'b0, den}) : r2;
      dvd <= {dvd[62:0], qbit};
    end
  end
endmodule

[hw/rtl/prh_dp.sv]
// Datapath: history memory, query walk registers, interpolation and result register.
module prh_dp import prh_pkg::*; #(
  parameter int CLIENTS       = 64,
  parameter int HISTORY_SLOTS = 128
) (
  input  logic                    clk,
  input  logic                    rst,
  input  prh_cmd_t                cmd,
  output prh_sts_t                sts,
  input  logic [5:0]              client,
  input  logic [TIME_W-1:0]       time_ms,
  input  logic [TIME_W-1:0]       command_time_ms,
  input  logic                    alive,
  input  logic signed [POS_W-1:0] pos_x,
  input  logic signed [POS_W-1:0] pos_y,
  input  logic signed [POS_W-1:0] pos_z,
  input  logic                    frame_end,
  input  logic                    cfg_valid,
  input  logic                    cfg_index,
  input  logic [MR_W-1:0]         cfg_data,
  output logic                    rsp_valid,
  input  logic                    rsp_ready,
  output logic [1:0]              status,
  output logic signed [POS_W-1:0] out_x,
  output logic signed [POS_W-1:0] out_y,
  output logic signed [POS_W-1:0] out_z,
  output logic [TIME_W-1:0]       used_time_ms
);
  localparam int CW    = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
  localparam int SW    = $clog2(HISTORY_SLOTS);
  localparam int AW    = CW + SW;
  localparam int DEPTH = 1 << AW;
  localparam logic [SW-1:0] LAST_SLOT = SW'(HISTORY_SLOTS - 1);

  prh_word_t mem [DEPTH];
  prh_word_t rdata;
  prh_word_t wdata;
  prh_word_t a_w;
  prh_word_t b_w;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [AW-1:0]     clr_addr;
  logic [SW-1:0]     head;
  logic [SW-1:0]     cap_slot;
  logic [SW-1:0]     idx;
  logic [SW-1:0]     n;
  logic [CW-1:0]     cidx;
  logic [CW-1:0]     q_cidx;
  logic              client_ok;
  logic [FT_W-1:0]   frame_time;
  logic [MR_W-1:0]   max_rewind;
  logic [FT_W-1:0]   ft_eff;
  logic signed [31:0] lag;
  logic              too_recent;
  logic [TIME_W-1:0] rt;
  logic              q_recent;
  logic [TIME_W-1:0] q_used;
  logic              have_a;
  logic              have_b;
  logic              den_pos;
  logic [1:0]        axis;
  logic signed [POS_W-1:0] av;
  logic signed [POS_W-1:0] bv;
  logic signed [32:0] diff;
  logic [32:0]       mag;
  logic [TIME_W-1:0] num;
  logic [62:0]       plo;
  logic [63:0]       prod;
  logic              neg_r;
  logic [32:0]       quo;
  logic              div_done;
  logic [POS_W-1:0]  res_val;
  logic signed [POS_W-1:0] res_x;
  logic signed [POS_W-1:0] res_y;
  logic signed [POS_W-1:0] res_z;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_time <= DEFAULT_FRAME_MS;
      max_rewind <= RESET_MAX_REWIND;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_FRAME_TIME: frame_time <= cfg_data[FT_W-1:0];
        REG_MAX_REWIND: max_rewind <= cfg_data;
        default: ;
      endcase
    end
  end

  assign client_ok = (int'(client) < CLIENTS);
  assign cidx      = CW'(client);
  assign cap_slot  = (head == LAST_SLOT) ? '0 : head + 1'b1;

  assign ft_eff     = (frame_time == '0) ? DEFAULT_FRAME_MS : frame_time;
  assign lag        = $signed({1'b0, time_ms}) - $signed({1'b0, command_time_ms});
  assign too_recent = lag < $signed({22'd0, ft_eff});
  assign rt = (lag > $signed({20'd0, max_rewind})) ? (time_ms - TIME_W'(max_rewind))
                                                   : command_time_ms;

  // History memory: clearing pass after reset, capture writes, walk reads.
  assign we    = cmd.clr | (cmd.cap & client_ok);
  assign waddr = cmd.clr ? clr_addr : {cidx, cap_slot};
  always_comb begin
    wdata     = '0;
    if (!cmd.clr) begin
      wdata.vld = alive;
      wdata.t   = time_ms;
      wdata.x   = pos_x;
      wdata.y   = pos_y;
      wdata.z   = pos_z;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (cmd.rd) rdata <= mem[{q_cidx, idx}];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      head     <= '0;
    end else begin
      if (cmd.clr) clr_addr <= clr_addr + 1'b1;
      if (cmd.cap && client_ok && frame_end) head <= cap_slot;
    end
  end

  // Query latch and newest-to-oldest walk.
  always_ff @(posedge clk) begin
    if (cmd.load_q) begin
      q_recent <= too_recent;
      q_used   <= too_recent ? command_time_ms : rt;
      q_cidx   <= cidx;
      idx      <= head;
      n        <= '0;
      have_a   <= 1'b0;
      have_b   <= 1'b0;
      axis     <= 2'd0;
    end else if (cmd.chk) begin
      if (rdata.vld) begin
        if (rdata.t >= q_used) begin
          have_a <= 1'b1;
          a_w    <= rdata;
        end else begin
          have_b <= 1'b1;
          b_w    <= rdata;
        end
      end
      idx <= (idx == '0) ? LAST_SLOT : idx - 1'b1;
      n   <= n + 1'b1;
    end else if (cmd.div_fin) begin
      axis <= axis + 2'd1;
    end
  end

  assign den_pos = a_w.t > b_w.t;

  // Interpolation: magnitude product into the divider, sign applied afterwards.
  always_comb begin
    case (axis)
      2'd0:    begin av = a_w.x; bv = b_w.x; end
      2'd1:    begin av = a_w.y; bv = b_w.y; end
      default: begin av = a_w.z; bv = b_w.z; end
    endcase
  end

  assign diff = {av[POS_W-1], av} - {bv[POS_W-1], bv};
  assign mag  = diff[32] ? (33'd0 - diff) : diff;
  assign num  = q_used - b_w.t;
  assign plo  = num * mag[31:0];
  assign prod = {1'b0, plo} + (mag[32] ? {1'b0, num, 32'd0} : 64'd0);

  always_ff @(posedge clk) begin
    if (cmd.mul) neg_r <= diff[32];
  end

  prh_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.mul),
    .dividend (prod),
    .divisor  (a_w.t - b_w.t),
    .done     (div_done),
    .quotient (quo)
  );

  assign res_val = bv + (neg_r ? (32'd0 - quo[31:0]) : quo[31:0]);

  always_ff @(posedge clk) begin
    if (cmd.div_fin) begin
      case (axis)
        2'd0:    res_x <= res_val;
        2'd1:    res_y <= res_val;
        default: res_z <= res_val;
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.out_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      used_time_ms <= q_used;
      if (q_recent) begin
        status <= ST_RECENT;
        out_x  <= '0;
        out_y  <= '0;
        out_z  <= '0;
      end else if (!have_a && !have_b) begin
        status <= ST_NO_HIST;
        out_x  <= '0;
        out_y  <= '0;
        out_z  <= '0;
      end else if (have_a && have_b && den_pos) begin
        status <= ST_POSITION;
        out_x  <= res_x;
        out_y  <= res_y;
        out_z  <= res_z;
      end else if (have_b) begin
        status <= ST_POSITION;
        out_x  <= b_w.x;
        out_y  <= b_w.y;
        out_z  <= b_w.z;
      end else begin
        status <= ST_POSITION;
        out_x  <= a_w.x;
        out_y  <= a_w.y;
        out_z  <= a_w.z;
      end
    end
  end

  assign sts.clr_last  = &clr_addr;
  assign sts.walk_go   = !too_recent && client_ok;
  assign sts.walk_stop = (rdata.vld && (rdata.t < q_used)) || (n == LAST_SLOT);
  assign sts.interp    = have_a && have_b && den_pos;
  assign sts.div_done  = div_done;
  assign sts.last_axis = (axis == 2'd2);
  assign sts.out_free  = !rsp_valid || rsp_ready;
endmodule

[hw/rtl/prh_ctrl.sv]
// Control state machine sequencing clearing, captures, the history walk and interpolation.
module prh_ctrl import prh_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     in_cmd,
  output logic     in_ready,
  input  prh_sts_t sts,
  output prh_cmd_t cmd
);
  typedef enum logic [7:0] {
    S_CLEAR  = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_RD     = 8'b0000_0100,
    S_CHK    = 8'b0000_1000,
    S_DECIDE = 8'b0001_0000,
    S_MUL    = 8'b0010_0000,
    S_DIV    = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          if (in_cmd) begin
            cmd.load_q = 1'b1;
            state_next = sts.walk_go ? S_RD : S_DONE;
          end else begin
            cmd.cap = 1'b1;
          end
        end
      end
      S_RD: begin
        cmd.rd     = 1'b1;
        state_next = S_CHK;
      end
      S_CHK: begin
        cmd.chk    = 1'b1;
        state_next = sts.walk_stop ? S_DECIDE : S_RD;
      end
      S_DECIDE: begin
        state_next = sts.interp ? S_MUL : S_DONE;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.div_fin = 1'b1;
          state_next  = sts.last_axis ? S_DONE : S_MUL;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end
endmodule

[hw/rtl/position_history_rewind.sv]
// Top level of the per-client position history rewind block.
// A capture transaction is accepted while idle and gives no result.
// A query walks up to HISTORY_SLOTS history slots, each in a read and a check state,
// through the single memory read port; to interpolate two samples, each axis passes a
// multiply state and the shared divider (one quotient bit per cycle); then the result
// register loads once free. After reset, before the first item is accepted, a clearing
// pass writes all 2**(clog2(CLIENTS)+clog2(HISTORY_SLOTS)) words (8192 by default).
module position_history_rewind import prh_pkg::*; #(
  parameter int CLIENTS       = 64,
  parameter int HISTORY_SLOTS = 128
) (
  input  logic        clk,
  input  logic        rst,
  prh_req_if.sink     req,
  prh_rsp_if.source   rsp,
  prh_cfg_if.sink     cfg
);
  prh_cmd_t cmd;
  prh_sts_t sts;

  assign cfg.ready = 1'b1;

  prh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_cmd   (req.cmd),
    .in_ready (req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  prh_dp #(
    .CLIENTS       (CLIENTS),
    .HISTORY_SLOTS (HISTORY_SLOTS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .client          (req.client),
    .time_ms         (req.time_ms),
    .command_time_ms (req.command_time_ms),
    .alive           (req.alive),
    .pos_x           (req.pos_x),
    .pos_y           (req.pos_y),
    .pos_z           (req.pos_z),
    .frame_end       (req.frame_end),
    .cfg_valid       (cfg.valid),
    .cfg_index       (cfg.index),
    .cfg_data        (cfg.data),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .status          (rsp.status),
    .out_x           (rsp.out_x),
    .out_y           (rsp.out_y),
    .out_z           (rsp.out_z),
    .used_time_ms    (rsp.used_time_ms)
  );
endmodule

[hw/rtl/prh_checker.sv]
// Port-level checker for the position history rewind block and its bind.
`include "position_history_rewind_macros.svh"

module prh_port_checker import prh_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        req_cmd,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [1:0]  status,
  input logic [31:0] out_x,
  input logic [31:0] out_y,
  input logic [31:0] out_z
);
  `PRH_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "Result dropped while stalled.")
  `PRH_ASSERT_NEXT(a_query_busy, req_valid && req_ready && req_cmd, !req_ready, "Query did not occupy the block.")
  `PRH_ASSERT_SAME(a_recent_zero, rsp_valid && status == ST_RECENT, out_x == '0 && out_y == '0 && out_z == '0, "Too recent result carries a position.")
  `PRH_ASSERT_SAME(a_nohist_zero, rsp_valid && status == ST_NO_HIST, out_x == '0 && out_y == '0 && out_z == '0, "No history result carries a position.")
endmodule

bind position_history_rewind prh_port_checker u_prh_port_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .req_cmd   (req.cmd),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .status    (rsp.status),
  .out_x     (rsp.out_x),
  .out_y     (rsp.out_y),
  .out_z     (rsp.out_z)
);

[test/prh_checker.sv]
// Checker that predicts and compares the results of the position history rewind block.
module prh_checker import prh_pkg::*; (
  input  logic clk,
  input  logic rst,
  prh_req_if   req,
  prh_rsp_if   rsp,
  prh_cfg_if   cfg,
  output int   errors,
  output int   pending,
  output int   n_blend,
  output int   n_single,
  output int   n_recent,
  output int   n_no_hist
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NCLI = 64;
  localparam int NSLOT = 128;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [30:0]        used;
  } rewind_result_t;

  logic [30:0]        hist_time[NCLI][NSLOT];
  bit                 hist_valid[NCLI][NSLOT];
  logic signed [31:0] hist_x[NCLI][NSLOT];
  logic signed [31:0] hist_y[NCLI][NSLOT];
  logic signed [31:0] hist_z[NCLI][NSLOT];
  int                 head;
  logic [FT_W-1:0]    frame_ms;
  logic [MR_W-1:0]    max_ms;
  rewind_result_t     expected_q[$];

  function automatic logic signed [31:0] lerp(logic signed [31:0] b, logic signed [31:0] a,
                                              longint num, longint den);
    logic signed [95:0] diff;
    logic signed [95:0] q;
    diff = 96'(signed'(a)) - 96'(signed'(b));
    q = (96'(num) * diff) / 96'(den);
    return 32'(96'(signed'(b)) + q);
  endfunction

  function automatic rewind_result_t rewind(int cl, longint now, longint target);
    rewind_result_t r;
    longint ft;
    longint rt;
    bit have_a;
    bit have_b;
    int ia;
    int ib;
    int idx;
    longint den;
    longint num;
    r = '0;
    rt = target;
    have_a = 0;
    have_b = 0;
    ia = 0;
    ib = 0;
    ft = (frame_ms == 0) ? longint'(DEFAULT_FRAME_MS) : longint'(frame_ms);
    if (now - rt < ft) begin
      r.status = ST_RECENT;
      r.used = 31'(rt);
      n_recent++;
      return r;
    end
    if (now - rt > longint'(max_ms)) rt = now - longint'(max_ms);
    r.used = 31'(rt);
    r.status = ST_NO_HIST;
    for (int n = 0; n < NSLOT; n++) begin
      idx = (head + NSLOT - n) % NSLOT;
      if (!hist_valid[cl][idx]) continue;
      if (longint'(hist_time[cl][idx]) >= rt) begin
        have_a = 1;
        ia = idx;
      end else begin
        have_b = 1;
        ib = idx;
        break;
      end
    end
    if (!have_a && !have_b) begin
      n_no_hist++;
      return r;
    end
    r.status = ST_POSITION;
    if (!have_a || !have_b) begin
      idx = have_a ? ia : ib;
      r.x = hist_x[cl][idx];
      r.y = hist_y[cl][idx];
      r.z = hist_z[cl][idx];
      n_single++;
      return r;
    end
    den = longint'(hist_time[cl][ia]) - longint'(hist_time[cl][ib]);
    num = rt - longint'(hist_time[cl][ib]);
    if (den <= 0) begin
      r.x = hist_x[cl][ib];
      r.y = hist_y[cl][ib];
      r.z = hist_z[cl][ib];
    end else begin
      r.x = lerp(hist_x[cl][ib], hist_x[cl][ia], num, den);
      r.y = lerp(hist_y[cl][ib], hist_y[cl][ia], num, den);
      r.z = lerp(hist_z[cl][ib], hist_z[cl][ia], num, den);
    end
    n_blend++;
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
    errors++;
  endtask

  initial begin
    errors = 0;
    n_blend = 0;
    n_single = 0;
    n_recent = 0;
    n_no_hist = 0;
    foreach (hist_valid[c, s]) hist_valid[c][s] = 0;
  end

  assign pending = expected_q.size();

  always @(posedge clk) begin
    rewind_result_t e;
    int s;
    if (rst) begin
      head <= 0;
      frame_ms <= DEFAULT_FRAME_MS;
      max_ms <= RESET_MAX_REWIND;
    end else begin
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == REG_FRAME_TIME) frame_ms <= cfg.data[FT_W-1:0];
        else max_ms <= cfg.data;
      end
      if (req.valid && req.ready) begin
        if (req.cmd) begin
          expected_q.push_back(rewind(req.client, req.time_ms, req.command_time_ms));
        end else begin
          s = (head + 1) % NSLOT;
          hist_time[req.client][s] = req.time_ms;
          hist_valid[req.client][s] = req.alive;
          hist_x[req.client][s] = req.pos_x;
          hist_y[req.client][s] = req.pos_y;
          hist_z[req.client][s] = req.pos_z;
          if (req.frame_end) head <= s;
        end
      end
      if (rsp.valid && rsp.ready) begin
        if (expected_q.size() == 0) begin
          report("unexpected transaction, status", 32'(rsp.status), 32'd0);
        end else begin
          e = expected_q.pop_front();
          if (rsp.status !== e.status) report("status", 32'(rsp.status), 32'(e.status));
          if (rsp.out_x !== e.x) report("out_x", rsp.out_x, e.x);
          if (rsp.out_y !== e.y) report("out_y", rsp.out_y, e.y);
          if (rsp.out_z !== e.z) report("out_z", rsp.out_z, e.z);
          if (rsp.used_time_ms !== e.used) begin
            report("used_time_ms", 32'(rsp.used_time_ms), 32'(e.used));
          end
        end
      end
    end
  end
endmodule

[test/tb.sv]
// Testbench top for the position history rewind block: stimulus, stalls and verdict.
module tb;
  import prh_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT = 4000000;

  logic clk;
  logic rst;
  int   errors;
  int   pending;
  int   n_blend;
  int   n_single;
  int   n_recent;
  int   n_no_hist;
  int   cycles = 0;
  int   n_sent;
  int   hold;
  longint clock_ms;

  prh_req_if req_ch();
  prh_rsp_if rsp_ch();
  prh_cfg_if cfg_ch();

  position_history_rewind dut (.clk(clk), .rst(rst), .req(req_ch), .rsp(rsp_ch), .cfg(cfg_ch));

  prh_checker chk (
    .clk(clk), .rst(rst), .req(req_ch), .rsp(rsp_ch), .cfg(cfg_ch), .errors(errors),
    .pending(pending), .n_blend(n_blend), .n_single(n_single), .n_recent(n_recent),
    .n_no_hist(n_no_hist)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb failed");
      $finish;
    end
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 0;
      hold <= 0;
    end else if (hold > 0) begin
      rsp_ch.ready <= 0;
      hold <= hold - 1;
    end else if ((cycles / 3000) % 4 == 0 || $urandom_range(2) != 0) begin
      rsp_ch.ready <= 1;
    end else begin
      rsp_ch.ready <= 0;
      hold <= gap_len();
    end
  end

  function automatic logic signed [31:0] rand_pos();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(1, 0) ? 32'sh7fffffff : 32'sh80000000;
      default: return signed'(32'($urandom_range(200000))) - 32'sd100000;
    endcase
  endfunction

  task automatic send(logic cmd, logic [5:0] cl, logic [30:0] t, logic [30:0] ct, logic alive,
                      logic signed [31:0] px, logic signed [31:0] py, logic signed [31:0] pz,
                      logic fe);
    int g;
    req_ch.valid <= 1;
    req_ch.cmd <= cmd;
    req_ch.client <= cl;
    req_ch.time_ms <= t;
    req_ch.command_time_ms <= ct;
    req_ch.alive <= alive;
    req_ch.pos_x <= px;
    req_ch.pos_y <= py;
    req_ch.pos_z <= pz;
    req_ch.frame_end <= fe;
    do @(posedge clk); while (!req_ch.ready);
    n_sent++;
    g = ((cycles / 5000) % 3 == 0) ? 0 : gap_len();
    if (g > 0) begin
      req_ch.valid <= 0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic capture(logic [5:0] cl, logic [30:0] t, logic alive, logic fe);
    send(0, cl, t, $urandom, alive, rand_pos(), rand_pos(), rand_pos(), fe);
  endtask

  task automatic query(logic [5:0] cl, logic [30:0] now, logic [30:0] target);
    send(1, cl, now, target, $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic write_reg(logic idx, logic [11:0] val);
    req_ch.valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    cfg_ch.valid <= 1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 0;
  endtask

  task automatic random_frames(int items);
    int k;
    int lag;
    logic [5:0] cl;
    k = 0;
    while (k < items) begin
      clock_ms += $urandom_range(5, 60);
      for (int c = 0; c < 4; c++) begin
        cl = ($urandom_range(9) == 0) ? 6'($urandom) : 6'(c);
        capture(cl, ($urandom_range(19) == 0) ? 31'($urandom) : 31'(clock_ms),
                $urandom_range(7) != 0, c == 3);
        k++;
      end
      repeat ($urandom_range(1, 3)) begin
        lag = ($urandom_range(9) == 0) ? -int'($urandom_range(200)) : $urandom_range(4500);
        cl = ($urandom_range(7) == 0) ? 6'($urandom) : 6'($urandom_range(3));
        if ($urandom_range(29) == 0) query(cl, 31'(clock_ms), $urandom);
        else query(cl, 31'(clock_ms), 31'(clock_ms - lag));
        k++;
      end
    end
  endtask

  initial begin
    logic [11:0] ft_vals[6];
    logic [11:0] mr_vals[6];
    n_sent = 0;
    rst <= 1;
    req_ch.valid <= 0;
    req_ch.cmd <= 0;
    req_ch.client <= 0;
    req_ch.time_ms <= 0;
    req_ch.command_time_ms <= 0;
    req_ch.alive <= 0;
    req_ch.pos_x <= 0;
    req_ch.pos_y <= 0;
    req_ch.pos_z <= 0;
    req_ch.frame_end <= 0;
    cfg_ch.valid <= 0;
    cfg_ch.index <= REG_FRAME_TIME;
    cfg_ch.data <= 0;
    repeat (4) @(posedge clk);
    rst <= 0;

    send(0, 0, 1000, 0, 1, 32'sh7fffffff, 32'sh80000000, 0, 0);
    send(0, 0, 0, 31'h7fffffff, 1, 0, 0, 0, 1);
    send(0, 0, 1100, 0, 1, 32'sh80000000, 32'sh7fffffff, -1, 1);
    send(0, 0, 1200, 0, 0, 5, 5, 5, 1);
    send(0, 63, 31'h7fffffff, 0, 1, 1234, -1234, 77, 1);
    query(0, 1150, 1125);
    query(0, 1150, 1126);
    query(0, 1150, 1160);
    query(0, 1200, 1050);
    query(0, 1300, 1000);
    query(0, 3000, 0);
    query(0, 1300, 10);
    query(0, 1150, 1099);
    query(0, 900, 500);
    query(0, 100, 0);
    query(5, 2000, 1500);
    query(63, 31'h7fffffff, 31'h7fffff00);
    query(63, 31'h7fffffff, 0);
    query(63, 0, 31'h7fffffff);
    query(63, 500, 0);

    ft_vals = '{12'd25, 12'd0, 12'd1, 12'd1023, 12'd1000, 12'($urandom_range(1, 200))};
    mr_vals = '{12'd1000, 12'd4095, 12'd1, 12'd0, 12'd4000, 12'($urandom_range(1, 4000))};
    clock_ms = $urandom_range(32'h7ff00000);
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_FRAME_TIME, ft_vals[ph]);
      write_reg(REG_MAX_REWIND, mr_vals[ph]);
      random_frames(250);
    end
    req_ch.valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    $display("sent %0d transactions over 6 register settings in %0d cycles", n_sent, cycles);
    $display("results: %0d blended, %0d single sample, %0d too recent, %0d no history",
             n_blend, n_single, n_recent, n_no_hist);
    if (errors == 0 && pending == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end
endmodule

[position_history_rewind.f]
+incdir+hw/rtl
hw/rtl/prh_pkg.sv
hw/rtl/prh_req_if.sv
hw/rtl/prh_rsp_if.sv
hw/rtl/prh_cfg_if.sv
hw/rtl/prh_div.sv
hw/rtl/prh_dp.sv
hw/rtl/prh_ctrl.sv
hw/rtl/position_history_rewind.sv
hw/rtl/prh_checker.sv
test/prh_checker.sv
test/tb.sv
